[rtl/goertzel_tone_power_defines.svh]
// Assertion macros shared by the goertzel_tone_power RTL.
`ifndef GOERTZEL_TONE_POWER_DEFINES_SVH
`define GOERTZEL_TONE_POWER_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define GTP_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define GTP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/gtp_pkg.sv]
// Types and constants shared by the Goertzel tone power detector.
package gtp_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int TONE_W     = 2;
    localparam int COEF_W     = 16;
    localparam int BLEN_W     = 11;
    localparam int STATE_W    = 48;
    localparam int POWER_W    = 48;
    localparam int NUM_COEF   = 4;
    localparam int NUM_TONES  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int MULT_W     = 48;
    localparam int CAND_W     = 64;
    localparam int ACC_W      = 66;
    localparam int STEP_W     = 6;
    localparam int REC_STEPS  = 16;
    localparam int POW_STEPS  = 48;
    localparam int FRAC_SHIFT = 14;
    localparam int IN_SHIFT   = 10;
    localparam int Q_SHIFT    = 2 * IN_SHIFT + FRAC_SHIFT;
    localparam int REM_W      = 7;

    localparam logic [REM_W:0] DIVISOR = 8'd100;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEN = 3'd4;

    localparam logic signed [COEF_W-1:0] COEF_0_RESET = 16'sd32170;
    localparam logic signed [COEF_W-1:0] COEF_1_RESET = 16'sd14876;
    localparam logic signed [COEF_W-1:0] COEF_2_RESET = 16'sd9032;
    localparam logic signed [COEF_W-1:0] COEF_3_RESET = 16'sd3212;
    localparam logic [BLEN_W-1:0]        BLEN_RESET   = 11'd200;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_REC,
        ST_MUL_CS2,
        ST_MUL_POW,
        ST_DIV,
        ST_DONE
    } gtp_state_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } mac_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mac_stat_t;

endpackage

[rtl/gtp_serial_mac.sv]
// Bit-serial dual shift-add multiply-accumulate unit, one multiplier bit per cycle.
module gtp_serial_mac
    import gtp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mac_ctrl_t                ctrl,
    input  logic signed [MULT_W-1:0] mult_a,
    input  logic signed [CAND_W-1:0] cand_a,
    input  logic signed [MULT_W-1:0] mult_b,
    input  logic signed [CAND_W-1:0] cand_b,
    output mac_stat_t                stat,
    output logic signed [ACC_W-1:0]  prod_hi,
    output logic [MULT_W-1:0]        prod_lo
);

    logic signed [MULT_W-1:0] ma_reg, ma_next, mb_reg, mb_next;
    logic signed [CAND_W-1:0] ca_reg, ca_next, cb_reg, cb_next;
    logic signed [ACC_W-1:0]  hi_reg, hi_next;
    logic [MULT_W-1:0]        lo_reg, lo_next;
    logic [STEP_W-1:0]        cnt_reg, cnt_next;
    logic                     busy_reg, busy_next, done_reg, done_next;
    logic                     last_step;
    logic signed [ACC_W-1:0]  ca_ext, cb_ext, add_a, add_b, sum;

    always_comb begin
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        ca_next   = ca_reg;
        cb_next   = cb_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        last_step = (cnt_reg == STEP_W'(1));
        ca_ext    = {{(ACC_W-CAND_W){ca_reg[CAND_W-1]}}, ca_reg};
        cb_ext    = {{(ACC_W-CAND_W){cb_reg[CAND_W-1]}}, cb_reg};
        add_a     = '0;
        add_b     = '0;
        if (ma_reg[0]) begin
            add_a = last_step ? -ca_ext : ca_ext;
        end
        if (mb_reg[0]) begin
            add_b = last_step ? -cb_ext : cb_ext;
        end
        sum = hi_reg + add_a + add_b;

        if (ctrl.start) begin
            ma_next   = mult_a;
            mb_next   = mult_b;
            ca_next   = cand_a;
            cb_next   = cand_b;
            hi_next   = '0;
            lo_next   = '0;
            cnt_next  = ctrl.steps;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            ma_next  = ma_reg >>> 1;
            mb_next  = mb_reg >>> 1;
            hi_next  = sum >>> 1;
            lo_next  = {sum[0], lo_reg[MULT_W-1:1]};
            cnt_next = cnt_reg - STEP_W'(1);
            if (last_step) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ma_reg <= ma_next;
        mb_reg <= mb_next;
        ca_reg <= ca_next;
        cb_reg <= cb_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod_hi   = hi_reg;
    assign prod_lo   = lo_reg;

endmodule

[rtl/goertzel_tone_power.sv]
// Goertzel single-bin tone power detector, top level with bit-serial datapath.
// Flow: a sample is accepted only in ST_IDLE, so each waits for the 16-step recurrence multiply
//   of the last; a closing sample adds the 16- and 48-step power multiplies and a 48-step divide
//   by 100 (skipped when the power clamps), then holds in ST_DONE until the output slot is free.
// Reset: synchronous active-low aresetn restores coefficients and block length to defaults
//   and clears filter state, sample count, latched tone and output valid.
`include "goertzel_tone_power_defines.svh"

module goertzel_tone_power
    import gtp_pkg::*;
#(
    parameter int MAX_BLOCK = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [SAMPLE_W-1:0]   s_sample,
    input  logic [TONE_W-1:0]     s_tone_index,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [POWER_W-1:0]    m_tone_power,
    output logic [TONE_W-1:0]     m_tone_used
);

    localparam int CNT_W   = $clog2(MAX_BLOCK + 1);
    localparam int REC_W   = STATE_W + 4;
    localparam int KEEP_LO = REC_STEPS - FRAC_SHIFT;
    localparam int QS_W    = ACC_W + MULT_W - Q_SHIFT;

    gtp_state_t state_reg, state_next;

    logic signed [COEF_W-1:0]  coef_reg [NUM_COEF];
    logic signed [COEF_W-1:0]  coef_next [NUM_COEF];
    logic [BLEN_W-1:0]         blen_reg, blen_next;
    logic signed [STATE_W-1:0] s1_reg, s1_next, s2_reg, s2_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [TONE_W-1:0]         tone_reg, tone_next;
    logic signed [COEF_W-1:0]  c_reg, c_next;
    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic                      last_reg, last_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [POWER_W-1:0]        quo_reg, quo_next;
    logic [STEP_W-1:0]         div_cnt_reg, div_cnt_next;
    logic                      m_valid_reg, m_valid_next;
    logic [POWER_W-1:0]        m_power_reg, m_power_next;
    logic [TONE_W-1:0]         m_tone_reg, m_tone_next;

    mac_ctrl_t                 mac_ctrl;
    mac_stat_t                 mac_stat;
    logic signed [MULT_W-1:0]  mac_mult_a, mac_mult_b;
    logic signed [CAND_W-1:0]  mac_cand_a, mac_cand_b;
    logic signed [ACC_W-1:0]   mac_hi;
    logic [MULT_W-1:0]         mac_lo;

    logic [TONE_W-1:0]         tone_pick, tone_sel;
    logic signed [COEF_W-1:0]  coef_sel;
    logic [CNT_W-1:0]          len_eff, count_inc;
    logic signed [SAMPLE_W-1:0] sample_x;
    logic [REC_W-1:0]          x_term, p14, s2_wide, rec_sum;
    logic [STATE_W-1:0]        rec_sat;
    logic [CAND_W-1:0]         cs2_prod, s1_scaled, s2_scaled, t_val;
    logic [QS_W-1:0]           qs;
    logic                      qs_neg, qs_over;
    logic [REM_W:0]            trial, diff;
    logic                      div_ge;

    gtp_serial_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .mult_a  (mac_mult_a),
        .cand_a  (mac_cand_a),
        .mult_b  (mac_mult_b),
        .cand_b  (mac_cand_b),
        .stat    (mac_stat),
        .prod_hi (mac_hi),
        .prod_lo (mac_lo)
    );

    always_comb begin
        tone_pick = (32'(s_tone_index) < NUM_TONES) ? s_tone_index : '0;
        tone_sel  = (count_reg == '0) ? tone_pick : tone_reg;
        coef_sel  = coef_reg[tone_sel];
        count_inc = count_reg + CNT_W'(1);
        if (blen_reg == '0) begin
            len_eff = CNT_W'(1);
        end else if (32'(blen_reg) > MAX_BLOCK) begin
            len_eff = CNT_W'(MAX_BLOCK);
        end else begin
            len_eff = CNT_W'(blen_reg);
        end

        // remove midscale offset
        sample_x = {~s_sample[SAMPLE_W-1], s_sample[SAMPLE_W-2:0]};

        x_term  = {{(REC_W-SAMPLE_W-IN_SHIFT){x_reg[SAMPLE_W-1]}}, x_reg, {IN_SHIFT{1'b0}}};
        p14     = {mac_hi[REC_W-KEEP_LO-1:0], mac_lo[MULT_W-1 -: KEEP_LO]};
        s2_wide = {{(REC_W-STATE_W){s2_reg[STATE_W-1]}}, s2_reg};
        rec_sum = x_term + p14 - s2_wide;
        if (rec_sum[REC_W-1:STATE_W-1] == '0 || rec_sum[REC_W-1:STATE_W-1] == '1) begin
            rec_sat = rec_sum[STATE_W-1:0];
        end else if (rec_sum[REC_W-1]) begin
            rec_sat = {1'b1, {(STATE_W-1){1'b0}}};
        end else begin
            rec_sat = {1'b0, {(STATE_W-1){1'b1}}};
        end

        cs2_prod  = {mac_hi[CAND_W-REC_STEPS-1:0], mac_lo[MULT_W-1 -: REC_STEPS]};
        s1_scaled = {{(CAND_W-STATE_W-FRAC_SHIFT){s1_reg[STATE_W-1]}}, s1_reg,
                     {FRAC_SHIFT{1'b0}}};
        s2_scaled = {{(CAND_W-STATE_W-FRAC_SHIFT){s2_reg[STATE_W-1]}}, s2_reg,
                     {FRAC_SHIFT{1'b0}}};
        t_val     = s1_scaled - cs2_prod;

        qs      = {mac_hi, mac_lo[MULT_W-1:Q_SHIFT]};
        qs_neg  = mac_hi[ACC_W-1];
        qs_over = (qs[QS_W-1:POWER_W+REM_W] != '0)
                  || ({1'b0, qs[POWER_W+REM_W-1:POWER_W]} >= DIVISOR);

        trial  = {rem_reg, quo_reg[POWER_W-1]};
        div_ge = (trial >= DIVISOR);
        diff   = trial - DIVISOR;
    end

    always_comb begin
        state_next   = state_reg;
        coef_next    = coef_reg;
        blen_next    = blen_reg;
        s1_next      = s1_reg;
        s2_next      = s2_reg;
        count_next   = count_reg;
        tone_next    = tone_reg;
        c_next       = c_reg;
        x_next       = x_reg;
        last_next    = last_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        div_cnt_next = div_cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_power_next = m_power_reg;
        m_tone_next  = m_tone_reg;
        s_ready      = 1'b0;
        mac_ctrl     = '{start: 1'b0, steps: STEP_W'(REC_STEPS)};
        mac_mult_a   = '0;
        mac_cand_a   = '0;
        mac_mult_b   = '0;
        mac_cand_b   = '0;

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_COEF_0: begin
                    coef_next[0] = $signed(cfg_wdata);
                end
                REG_COEF_1: begin
                    coef_next[1] = $signed(cfg_wdata);
                end
                REG_COEF_2: begin
                    coef_next[2] = $signed(cfg_wdata);
                end
                REG_COEF_3: begin
                    coef_next[3] = $signed(cfg_wdata);
                end
                REG_BLOCK_LEN: begin
                    blen_next = cfg_wdata[BLEN_W-1:0];
                end
                default: begin
                end
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                mac_mult_a = {{(MULT_W-COEF_W){coef_sel[COEF_W-1]}}, coef_sel};
                mac_cand_a = {{(CAND_W-STATE_W){s1_reg[STATE_W-1]}}, s1_reg};
                if (s_valid) begin
                    mac_ctrl.start = 1'b1;
                    tone_next      = tone_sel;
                    c_next         = coef_sel;
                    x_next         = sample_x;
                    count_next     = count_inc;
                    last_next      = (count_inc >= len_eff);
                    state_next     = ST_MUL_REC;
                end
            end
            ST_MUL_REC: begin
                mac_mult_a = {{(MULT_W-COEF_W){c_reg[COEF_W-1]}}, c_reg};
                mac_cand_a = {{(CAND_W-STATE_W){s1_reg[STATE_W-1]}}, s1_reg};
                if (mac_stat.done) begin
                    s2_next = s1_reg;
                    s1_next = rec_sat;
                    if (last_reg) begin
                        mac_ctrl.start = 1'b1;
                        state_next     = ST_MUL_CS2;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MUL_CS2: begin
                mac_ctrl.steps = STEP_W'(POW_STEPS);
                mac_mult_a     = s1_reg;
                mac_cand_a     = t_val;
                mac_mult_b     = s2_reg;
                mac_cand_b     = s2_scaled;
                if (mac_stat.done) begin
                    mac_ctrl.start = 1'b1;
                    state_next     = ST_MUL_POW;
                end
            end
            ST_MUL_POW: begin
                if (mac_stat.done) begin
                    if (qs_neg) begin
                        quo_next   = '0;
                        state_next = ST_DONE;
                    end else if (qs_over) begin
                        quo_next   = '1;
                        state_next = ST_DONE;
                    end else begin
                        rem_next     = qs[POWER_W+REM_W-1:POWER_W];
                        quo_next     = qs[POWER_W-1:0];
                        div_cnt_next = STEP_W'(POWER_W);
                        state_next   = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                rem_next     = div_ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
                quo_next     = {quo_reg[POWER_W-2:0], div_ge};
                div_cnt_next = div_cnt_reg - STEP_W'(1);
                if (div_cnt_reg == STEP_W'(1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_power_next = quo_reg;
                    m_tone_next  = tone_reg;
                    s1_next      = '0;
                    s2_next      = '0;
                    count_next   = '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            coef_reg[0] <= COEF_0_RESET;
            coef_reg[1] <= COEF_1_RESET;
            coef_reg[2] <= COEF_2_RESET;
            coef_reg[3] <= COEF_3_RESET;
            blen_reg    <= BLEN_RESET;
            s1_reg      <= '0;
            s2_reg      <= '0;
            count_reg   <= '0;
            tone_reg    <= '0;
            last_reg    <= 1'b0;
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            coef_reg    <= coef_next;
            blen_reg    <= blen_next;
            s1_reg      <= s1_next;
            s2_reg      <= s2_next;
            count_reg   <= count_next;
            tone_reg    <= tone_next;
            last_reg    <= last_next;
            div_cnt_reg <= div_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        c_reg       <= c_next;
        x_reg       <= x_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        m_power_reg <= m_power_next;
        m_tone_reg  <= m_tone_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_tone_power = m_power_reg;
    assign m_tone_used  = m_tone_reg;

    `GTP_ASSERT_SAME(a_mac_in_mul_state, mac_stat.busy || mac_stat.done, state_reg == ST_MUL_REC || state_reg == ST_MUL_CS2 || state_reg == ST_MUL_POW, "multiplier active outside a multiply state")
    `GTP_ASSERT_NEXT(a_accept_starts_mac, s_valid && s_ready, state_reg == ST_MUL_REC && mac_stat.busy, "sample transaction did not start the recurrence multiply")
    `GTP_ASSERT_SAME(a_rem_below_divisor, state_reg == ST_DIV, {1'b0, rem_reg} < DIVISOR, "divider remainder reached the divisor")
    `GTP_ASSERT_SAME(a_count_in_block, state_reg == ST_IDLE, 32'(count_reg) < MAX_BLOCK, "sample count reached the block limit while idle")

endmodule

[tb/sv/tb_goertzel_tone_power.sv]
// Self-checking testbench for the Goertzel tone power detector.
`timescale 1ns / 100ps

module tb_goertzel_tone_power;
    import gtp_pkg::*;

    localparam int     BLOCK_CAP     = 1024;
    localparam int     SETTLE_CYCLES = 160;
    localparam int     CYCLE_LIMIT   = 1000000;
    localparam longint S48_MAX       = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint S48_MIN       = -S48_MAX - 1;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [SAMPLE_W-1:0] code;
        logic [TONE_W-1:0]   tone;
    } adc_word_t;

    typedef struct packed {
        logic [POWER_W-1:0] power;
        logic [TONE_W-1:0]  tone;
    } tone_power_t;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [SAMPLE_W-1:0]   s_sample     = '0;
    logic [TONE_W-1:0]     s_tone_index = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [POWER_W-1:0]    m_tone_power;
    logic [TONE_W-1:0]     m_tone_used;

    adc_word_t   sample_q[$];
    tone_power_t expected_q[$];
    adc_word_t   next_word;
    tone_power_t want;

    int samples_sent   = 0;
    int samples_taken  = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;

    logic signed [COEF_W-1:0] coef_reg[NUM_COEF] = '{16'sd32170, 16'sd14876, 16'sd9032,
                                                     16'sd3212};
    logic [BLEN_W-1:0]        len_reg      = 11'd200;
    longint                   s1           = 0;
    longint                   s2           = 0;
    int                       block_taken  = 0;
    logic [TONE_W-1:0]        held_tone    = '0;

    goertzel_tone_power #(
        .MAX_BLOCK(BLOCK_CAP)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .s_tone_index(s_tone_index),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_tone_power(m_tone_power),
        .m_tone_used (m_tone_used)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [POWER_W-1:0] block_energy(longint a1, longint a2,
                                                        logic signed [COEF_W-1:0] c);
        logic signed [127:0] p;
        logic signed [127:0] q;
        logic signed [127:0] w;
        logic signed [127:0] energy;
        logic [127:0]        quot;
        p = a1;
        q = a2;
        w = c;
        energy = ((p * p + q * q) <<< FRAC_SHIFT) - w * p * q;
        if (energy < 0) begin
            return '0;
        end
        quot = energy[127:34] / 100;
        if (quot > {POWER_W{1'b1}}) begin
            return {POWER_W{1'b1}};
        end
        return quot[POWER_W-1:0];
    endfunction

    function automatic void accumulate_sample(logic [SAMPLE_W-1:0] code,
                                              logic [TONE_W-1:0] tone_in);
        longint                   x;
        longint                   lag;
        longint                   s0;
        int                       span;
        logic signed [COEF_W-1:0] c;
        tone_power_t              res;
        span = (len_reg == 0) ? 1 : ((len_reg > BLOCK_CAP) ? BLOCK_CAP : int'(len_reg));
        if (block_taken == 0) begin
            held_tone = (tone_in < NUM_TONES) ? tone_in : '0;
        end
        c   = coef_reg[held_tone];
        x   = longint'(code) - 512;
        lag = (longint'(c) * s1) >>> FRAC_SHIFT;
        s0  = x * 1024 + lag - s2;
        if (s0 > S48_MAX) begin
            s0 = S48_MAX;
        end else if (s0 < S48_MIN) begin
            s0 = S48_MIN;
        end
        s2 = s1;
        s1 = s0;
        block_taken++;
        if (block_taken >= span) begin
            res.power = block_energy(s1, s2, c);
            res.tone  = held_tone;
            expected_q.push_back(res);
            s1 = 0;
            s2 = 0;
            block_taken = 0;
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch @%0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Driver: present the next pending sample once the current one is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_word = sample_q.pop_front();
                s_valid      <= 1'b1;
                s_sample     <= next_word.code;
                s_tone_index <= next_word.tone;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: predict on each input transaction, check each result transaction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                accumulate_sample(s_sample, s_tone_index);
                samples_taken++;
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result power=%0d tone=%0d",
                                              m_tone_power, m_tone_used));
                end else begin
                    want = expected_q.pop_front();
                    if (m_tone_power !== want.power) begin
                        report_mismatch($sformatf("tone_power got %0d want %0d",
                                                  m_tone_power, want.power));
                    end
                    if (m_tone_used !== want.tone) begin
                        report_mismatch($sformatf("tone_used got %0d want %0d",
                                                  m_tone_used, want.tone));
                    end
                end
            end
        end
    end

    task automatic queue_sample(logic [SAMPLE_W-1:0] code, logic [TONE_W-1:0] tone);
        adc_word_t w;
        w.code = code;
        w.tone = tone;
        sample_q.push_back(w);
        samples_sent++;
    endtask

    task automatic wait_drained();
        while (samples_taken != samples_sent || expected_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_COEF_0, REG_COEF_1, REG_COEF_2, REG_COEF_3: coef_reg[idx[1:0]] = data;
            REG_BLOCK_LEN: len_reg = data[BLEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic cfg_close();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_code();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return SAMPLE_W'($urandom_range(505, 519));
            default: return SAMPLE_W'($urandom_range(1023));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_coef();
        case ($urandom_range(5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return CFG_DATA_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_len();
        logic [CFG_DATA_W-1:0] v;
        v = CFG_DATA_W'($urandom);
        case ($urandom_range(9))
            0:       v[BLEN_W-1:0] = '0;
            1:       v[BLEN_W-1:0] = BLEN_W'($urandom_range(25, 300));
            default: v[BLEN_W-1:0] = BLEN_W'($urandom_range(1, 24));
        endcase
        return v;
    endfunction

    task automatic random_phase();
        int n;
        wait_drained();
        for (int k = 0; k < NUM_COEF; k++) begin
            if ($urandom_range(1)) begin
                cfg_write(REG_COEF_0 + CFG_IDX_W'(k), pick_coef());
            end
        end
        if ($urandom_range(1)) begin
            cfg_write(REG_BLOCK_LEN, pick_len());
        end
        if ($urandom_range(3) == 0) begin
            cfg_write(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                      CFG_DATA_W'($urandom));
        end
        cfg_close();
        n = $urandom_range(10, 60);
        repeat (n) queue_sample(pick_code(), TONE_W'($urandom_range(3)));
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 8;
        recv_idle_pct = 80;

        // One block on the reset configuration.
        repeat (200) queue_sample(pick_code(), TONE_W'($urandom_range(3)));
        wait_drained();

        // Single-sample blocks, extreme coefficients, ignored indexes.
        cfg_write(REG_COEF_0, 16'h7FFF);
        cfg_write(REG_COEF_1, 16'h8000);
        cfg_write(REG_COEF_2, 16'h0000);
        cfg_write(REG_COEF_3, 16'hFFFF);
        cfg_write(REG_BLOCK_LEN, 16'h0000);
        cfg_write(REG_SPARE_FIRST, 16'h0001);
        cfg_write(REG_SPARE_LAST, 16'hFFFE);
        cfg_close();
        queue_sample(10'd0, 2'd0);
        queue_sample(10'd1023, 2'd1);
        queue_sample(10'd512, 2'd2);
        queue_sample(10'd1023, 2'd3);
        queue_sample(10'd0, 2'd1);
        queue_sample(10'd511, 2'd2);
        queue_sample(10'd513, 2'd0);
        queue_sample(10'd1023, 2'd0);
        wait_drained();

        // Shrink the length below the count already taken.
        cfg_write(REG_BLOCK_LEN, 16'd10);
        cfg_close();
        queue_sample(10'd1023, 2'd1);
        queue_sample(10'd0, 2'd0);
        queue_sample(10'd700, 2'd2);
        queue_sample(10'd1023, 2'd3);
        queue_sample(10'd100, 2'd0);
        wait_drained();
        cfg_write(REG_BLOCK_LEN, 16'd3);
        cfg_close();
        queue_sample(10'd1023, 2'd2);
        queue_sample(10'd0, 2'd3);
        queue_sample(10'd1023, 2'd3);
        queue_sample(10'd0, 2'd3);
        wait_drained();

        // Length above the cap holds the block open, then a short length closes it.
        cfg_write(REG_COEF_0, 16'h7FFF);
        cfg_write(REG_BLOCK_LEN, 16'hFFFF);
        cfg_close();
        repeat (30) queue_sample(10'd1023, 2'd0);
        wait_drained();
        cfg_write(REG_BLOCK_LEN, 16'd2);
        cfg_close();
        queue_sample(10'd1023, 2'd0);

        for (int mode = 0; mode < 3; mode++) begin
            wait_drained();
            send_idle_pct = (mode == 0) ? 8 : ((mode == 1) ? 80 : 0);
            recv_idle_pct = (mode == 0) ? 80 : ((mode == 1) ? 8 : 0);
            repeat (5) random_phase();
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
